[hw/rtl/acmm_pkg.sv]
// ============================================================================
// acmm_pkg: shared types and constants of the channel matrix mixer
// Sample, weight and accumulator widths, register indexes, lane control.
// ============================================================================
package acmm_pkg;

   // Field widths
   localparam int SAMPLE_W = 16;   // signed audio sample
   localparam int COEF_W   = 8;    // unsigned Q1.7 weight
   localparam int COUNT_W  = 3;    // channel count registers
   localparam int CLAMP_W  = 4;    // clamped count, holds up to eight
   localparam int FRAC_W   = 7;    // fraction bits of a weight

   // Product of a 9-bit signed weight and a 16-bit sample
   localparam int PROD_W   = SAMPLE_W + COEF_W + 1;
   // Sum of up to eight products
   localparam int SUM_W    = PROD_W + 3;
   // Quotient after dropping the fraction bits
   localparam int QUO_W    = SUM_W - FRAC_W;

   localparam int SAMPLE_MAX = 32767;
   localparam int SAMPLE_MIN = -32768;

   // Register indexes on the csr port
   localparam int REG_IN_CHANNELS  = 0;
   localparam int REG_OUT_CHANNELS = 1;
   localparam int REG_COEF_BASE    = 2;

   // Per-cycle control shared by every lane
   typedef struct packed {
      logic               ld_mul;   // product stage loads
      logic               ld_sum;   // sum stage loads
      logic               ld_out;   // output stage loads
      logic               mute;     // word at the input is muted
      logic [CLAMP_W-1:0] nin;      // active input channels, clamped
   } lane_ctl_type;

endpackage

[hw/rtl/acmm_lane.sv]
// ============================================================================
// acmm_lane: one output channel of the mixing matrix
// Three stages: weighted products, product sum, truncate and saturate.
// ============================================================================
module acmm_lane #(
   parameter int MAX_CHANNELS = 6
) (
   input  logic                                            clock,
   input  acmm_pkg::lane_ctl_type                          ctl,
   input  logic                                            active,
   input  logic [MAX_CHANNELS-1:0][acmm_pkg::SAMPLE_W-1:0] samples,
   input  logic [acmm_pkg::COEF_W*MAX_CHANNELS-1:0]        coef_row,
   output logic [acmm_pkg::SAMPLE_W-1:0]                   sample_out
);

   logic signed [acmm_pkg::PROD_W-1:0] prod_in [MAX_CHANNELS];
   logic signed [acmm_pkg::PROD_W-1:0] prod_ff [MAX_CHANNELS];
   logic                               kill1_in;
   logic                               kill1_ff;

   logic signed [acmm_pkg::SUM_W-1:0]  sum_in;
   logic signed [acmm_pkg::SUM_W-1:0]  sum_ff;
   logic                               kill2_ff;

   logic signed [acmm_pkg::SUM_W-1:0]  biased;
   logic signed [acmm_pkg::QUO_W-1:0]  quo;
   logic [acmm_pkg::SAMPLE_W-1:0]      out_in;
   logic [acmm_pkg::SAMPLE_W-1:0]      out_ff;

   // Stage 1: weight times sample for each active input
   always_comb begin
      for (int k = 0; k < MAX_CHANNELS; k++) begin
         if (acmm_pkg::CLAMP_W'(k) < ctl.nin) begin
            prod_in[k] = $signed({1'b0, coef_row[acmm_pkg::COEF_W*k +: acmm_pkg::COEF_W]})
                         * $signed(samples[k]);
         end else begin
            prod_in[k] = '0;
         end
      end
      kill1_in = ctl.mute || !active;
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_mul) begin
         prod_ff  <= prod_in;
         kill1_ff <= kill1_in;
      end
   end

   // Stage 2: sum of the products
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < MAX_CHANNELS; k++) begin
         sum_in = sum_in + acmm_pkg::SUM_W'(prod_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_sum) begin
         sum_ff   <= sum_in;
         kill2_ff <= kill1_ff;
      end
   end

   // Stage 3: divide by 128 toward zero, then clamp to 16 bits; muted or inactive words give zero
   always_comb begin
      biased = sum_ff + $signed({{(acmm_pkg::SUM_W-acmm_pkg::FRAC_W){1'b0}},
                                 {acmm_pkg::FRAC_W{sum_ff[acmm_pkg::SUM_W-1]}}});
      quo    = biased[acmm_pkg::SUM_W-1:acmm_pkg::FRAC_W];
      if (kill2_ff) begin
         out_in = '0;
      end else if (quo > acmm_pkg::QUO_W'(acmm_pkg::SAMPLE_MAX)) begin
         out_in = acmm_pkg::SAMPLE_W'(acmm_pkg::SAMPLE_MAX);
      end else if (quo < acmm_pkg::QUO_W'(acmm_pkg::SAMPLE_MIN)) begin
         out_in = acmm_pkg::SAMPLE_W'(acmm_pkg::SAMPLE_MIN);
      end else begin
         out_in = quo[acmm_pkg::SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_out) begin
         out_ff <= out_in;
      end
   end

   assign sample_out = out_ff;

endmodule

[hw/rtl/audio_channel_matrix_mixer.sv]
// ============================================================================
// audio_channel_matrix_mixer: weighted channel mixing of sample frames
// Control registers, pipeline handshake and one lane per output channel.
// ============================================================================
// One frame enters per cycle while the result side accepts, and its mix
// passes through the per-lane pipeline of multiply, sum and
// truncate/saturate stages, and every output channel has its own lane so
// all channels finish together. The input only holds when the result
// side stalls with all three stages full; empty stages are filled even while
// a finished word waits. Registers (in_channels, out_channels, coef_row_0..)
// are written through the csr port and must only change while no frame is in
// flight. Reset loads two active channels and identity weights.
module audio_channel_matrix_mixer #(
   parameter int MAX_CHANNELS = 6
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // slave side
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // tdata: sample_in_0, sample_in_1, ... sample_in_<MAX_CHANNELS-1>
   input  logic [acmm_pkg::SAMPLE_W*MAX_CHANNELS-1:0] req_tdata,
   // tuser: muted
   input  logic                                       req_tuser,
   // master side
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // tdata: sample_out_0, sample_out_1, ... sample_out_<MAX_CHANNELS-1>
   output logic [acmm_pkg::SAMPLE_W*MAX_CHANNELS-1:0] rsp_tdata,
   // configuration
   input  logic                                       csr_we,
   input  logic [$clog2(MAX_CHANNELS+2)-1:0]          csr_index,
   input  logic [acmm_pkg::COEF_W*MAX_CHANNELS-1:0]   csr_wdata
);

   localparam int IDX_W = $clog2(MAX_CHANNELS+2);
   localparam int ROW_W = acmm_pkg::COEF_W * MAX_CHANNELS;

   logic [acmm_pkg::COUNT_W-1:0] in_channels_ff;
   logic [acmm_pkg::COUNT_W-1:0] out_channels_ff;
   logic [ROW_W-1:0]             coef_ff [MAX_CHANNELS];

   logic [acmm_pkg::CLAMP_W-1:0] nin;
   logic [acmm_pkg::CLAMP_W-1:0] nout;

   logic v1_ff, v2_ff, v3_ff;
   logic ld1, ld2, ld3;

   acmm_pkg::lane_ctl_type                          ctl;
   logic [MAX_CHANNELS-1:0][acmm_pkg::SAMPLE_W-1:0] samples;
   logic [MAX_CHANNELS-1:0][acmm_pkg::SAMPLE_W-1:0] mixed;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_channels_ff  <= acmm_pkg::COUNT_W'(2);
         out_channels_ff <= acmm_pkg::COUNT_W'(2);
         for (int j = 0; j < MAX_CHANNELS; j++) begin
            coef_ff[j] <= ROW_W'(128) << (acmm_pkg::COEF_W * j);
         end
      end else if (csr_we) begin
         if (csr_index == IDX_W'(acmm_pkg::REG_IN_CHANNELS)) begin
            in_channels_ff <= csr_wdata[acmm_pkg::COUNT_W-1:0];
         end
         if (csr_index == IDX_W'(acmm_pkg::REG_OUT_CHANNELS)) begin
            out_channels_ff <= csr_wdata[acmm_pkg::COUNT_W-1:0];
         end
         for (int j = 0; j < MAX_CHANNELS; j++) begin
            if (csr_index == IDX_W'(acmm_pkg::REG_COEF_BASE + j)) begin
               coef_ff[j] <= csr_wdata;
            end
         end
      end
   end

   // Counts above the lane count clamp to it
   always_comb begin
      nin  = (acmm_pkg::CLAMP_W'(in_channels_ff) > acmm_pkg::CLAMP_W'(MAX_CHANNELS))
             ? acmm_pkg::CLAMP_W'(MAX_CHANNELS) : acmm_pkg::CLAMP_W'(in_channels_ff);
      nout = (acmm_pkg::CLAMP_W'(out_channels_ff) > acmm_pkg::CLAMP_W'(MAX_CHANNELS))
             ? acmm_pkg::CLAMP_W'(MAX_CHANNELS) : acmm_pkg::CLAMP_W'(out_channels_ff);
   end

   // Stage loads: a stage takes new data when empty or when it drains
   always_comb begin
      ld3 = !v3_ff || rsp_tready;
      ld2 = !v2_ff || ld3;
      ld1 = !v1_ff || ld2;
   end

   assign req_tready = ld1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ld1) v1_ff <= req_tvalid;
         if (ld2) v2_ff <= v1_ff;
         if (ld3) v3_ff <= v2_ff;
      end
   end

   // Lane control
   always_comb begin
      ctl.ld_mul = ld1;
      ctl.ld_sum = ld2;
      ctl.ld_out = ld3;
      ctl.mute   = req_tuser;
      ctl.nin    = nin;
   end

   assign samples = req_tdata;

   // One lane per output channel
   for (genvar j = 0; j < MAX_CHANNELS; j++) begin : g_lane
      acmm_lane #(
         .MAX_CHANNELS (MAX_CHANNELS)
      ) u_lane (
         .clock      (clock),
         .ctl        (ctl),
         .active     (acmm_pkg::CLAMP_W'(j) < nout),
         .samples    (samples),
         .coef_row   (coef_ff[j]),
         .sample_out (mixed[j])
      );
   end

   // Merge lane results into the outgoing word
   assign rsp_tdata  = mixed;
   assign rsp_tvalid = v3_ff;

endmodule

[hw/rtl/acmm_checker.sv]
// ============================================================================
// acmm_checker: port-level checks of the channel matrix mixer
// Latency, flow control and reset behavior seen from the ports.
// ============================================================================
module acmm_checker #(
   parameter int MAX_CHANNELS = 6
) (
   input logic                                       clock,
   input logic                                       reset,
   input logic                                       req_tvalid,
   input logic                                       req_tready,
   input logic                                       rsp_tvalid,
   input logic                                       rsp_tready,
   input logic [acmm_pkg::SAMPLE_W*MAX_CHANNELS-1:0] rsp_tdata
);

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // An empty or draining output never blocks the input
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input refused while output can move");

   // A rising result valid must trace back to an accepted input word
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 3))
      else $error("result without matching input word");

   // A stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind audio_channel_matrix_mixer acmm_checker #(
   .MAX_CHANNELS (MAX_CHANNELS)
) u_acmm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
